FILE: hdl/caf_pkg.sv
// ----------------------------------------------------------------------------
// Frame assembler package
// Shared codes, byte constants and types for the frame assembler.
// ----------------------------------------------------------------------------
package caf_pkg;

   localparam logic [1:0] ACT_DATA  = 2'd0;
   localparam logic [1:0] ACT_EMPTY = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   localparam logic [7:0] HDR_FIRST  = 8'h19;
   localparam logic [7:0] HDR_SECOND = 8'h68;
   localparam logic [7:0] FILL_BYTE  = 8'hFF;

   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_HELD   = 4'b0010,
      MODE_APPEND = 4'b0100,
      MODE_SKIP   = 4'b1000
   } caf_mode_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_HEADER = 2'd2,
      OP_READ   = 2'd3
   } caf_op_type;

   typedef struct packed {
      logic        frame_done;
      logic [1:0]  done_buffer;
      logic [16:0] done_length;
      logic        packet_dropped;
      logic        packet_ignored;
   } caf_result_type;

endpackage

FILE: hdl/caf_front.sv
// ----------------------------------------------------------------------------
// Frame assembler front end
// Holds the packet and frame state, classifies each word and issues at most one
// memory operation together with its status fields.
// ----------------------------------------------------------------------------
module caf_front #(
   parameter int FRAME_BYTES = 65536,
   parameter int NUM_BUFFERS = 3,
   localparam int BUF_W = $clog2(NUM_BUFFERS),
   localparam int OFF_W = $clog2(FRAME_BYTES)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data,
   input  logic                    accept,
   input  logic [1:0]              action,
   input  logic [7:0]              data_byte,
   input  logic                    first_of_packet,
   input  logic [9:0]              packet_len,
   input  logic [1:0]              read_buffer,
   input  logic [15:0]             read_address,
   output caf_pkg::caf_result_type ent_res,
   output caf_pkg::caf_op_type     ent_op,
   output logic [BUF_W-1:0]        ent_buf,
   output logic [OFF_W-1:0]        ent_off,
   output logic [7:0]              ent_data
);
   import caf_pkg::*;

   localparam int LEN_W = $clog2(FRAME_BYTES + 1);
   localparam int SUM_W = ((LEN_W > 10) ? LEN_W : 10) + 1;

   logic               enable_ff;
   caf_mode_type       mode_ff, mode_in;
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic [2:0]         trail_ff, trail_in;
   logic [BUF_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [7:0]         held_ff, held_in;
   logic               put;
   logic [SUM_W-1:0]   sum;

   always_comb begin
      mode_in   = mode_ff;
      fill_in   = fill_ff;
      trail_in  = trail_ff;
      wr_idx_in = wr_idx_ff;
      held_in   = held_ff;
      ent_res   = '0;
      ent_op    = OP_NONE;
      ent_buf   = wr_idx_ff;
      ent_off   = fill_ff[OFF_W-1:0];
      ent_data  = data_byte;
      put       = 1'b0;
      sum       = SUM_W'(fill_ff) + SUM_W'(packet_len);

      if (action == ACT_READ) begin
         ent_buf = BUF_W'(read_buffer);
         ent_off = OFF_W'(read_address);
         if ((32'(read_buffer) < NUM_BUFFERS) && (32'(read_address) < FRAME_BYTES)) begin
            ent_op = OP_READ;
         end
      end else if ((action == ACT_DATA) && enable_ff) begin
         if (first_of_packet) begin
            ent_res.packet_ignored = (mode_ff == MODE_HELD);
            if (sum > SUM_W'(FRAME_BYTES)) begin
               ent_res.packet_dropped = 1'b1;
               mode_in = MODE_SKIP;
            end else if (fill_ff != '0) begin
               mode_in = MODE_APPEND;
               put     = 1'b1;
            end else if (packet_len < 10'd2) begin
               ent_res.packet_ignored = 1'b1;
               mode_in = MODE_SKIP;
            end else begin
               held_in = data_byte;
               mode_in = MODE_HELD;
            end
         end else begin
            unique case (mode_ff) inside
               MODE_HELD: begin
                  if ((held_ff == HDR_FIRST) && (data_byte == HDR_SECOND)) begin
                     ent_op   = OP_HEADER;
                     fill_in  = fill_ff + LEN_W'(2);
                     trail_in = 3'd0;
                     mode_in  = MODE_APPEND;
                  end else begin
                     ent_res.packet_ignored = 1'b1;
                     mode_in = MODE_SKIP;
                  end
               end
               MODE_APPEND: begin
                  put = 1'b1;
               end
               MODE_IDLE, MODE_SKIP: begin
               end
               default: begin
               end
            endcase
         end
      end else if ((action == ACT_EMPTY) && enable_ff) begin
         ent_res.packet_ignored = (mode_ff == MODE_HELD);
         mode_in = MODE_IDLE;
         if ((fill_ff > LEN_W'(4)) && (trail_ff >= 3'd4)) begin
            ent_res.frame_done  = 1'b1;
            ent_res.done_buffer = 2'(wr_idx_ff);
            ent_res.done_length = 17'(fill_ff);
            wr_idx_in = (wr_idx_ff == BUF_W'(NUM_BUFFERS - 1)) ? '0 : wr_idx_ff + 1'b1;
            fill_in   = '0;
            trail_in  = 3'd0;
         end
      end

      if (put && (fill_ff < LEN_W'(FRAME_BYTES))) begin
         ent_op  = OP_WRITE;
         fill_in = fill_ff + 1'b1;
         if (data_byte == FILL_BYTE) begin
            trail_in = (trail_ff < 3'd4) ? trail_ff + 3'd1 : trail_ff;
         end else begin
            trail_in = 3'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         mode_ff   <= MODE_IDLE;
         fill_ff   <= '0;
         trail_ff  <= 3'd0;
         wr_idx_ff <= BUF_W'(1);
         held_ff   <= 8'd0;
      end else begin
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
         if (accept) begin
            mode_ff   <= mode_in;
            fill_ff   <= fill_in;
            trail_ff  <= trail_in;
            wr_idx_ff <= wr_idx_in;
            held_ff   <= held_in;
         end
      end
   end

endmodule

FILE: hdl/caf_queue.sv
// ----------------------------------------------------------------------------
// Frame assembler queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module caf_queue #(
   parameter int WIDTH = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);
   import caf_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign head_data = slot_ff[rd_ptr_ff];
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: hdl/caf_back.sv
// ----------------------------------------------------------------------------
// Frame assembler back end
// Carries out the queued memory operations on the frame memory and presents
// each result through an output register.
// ----------------------------------------------------------------------------
module caf_back #(
   parameter int FRAME_BYTES = 65536,
   parameter int NUM_BUFFERS = 3,
   localparam int BUF_W = $clog2(NUM_BUFFERS),
   localparam int OFF_W = $clog2(FRAME_BYTES)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  caf_pkg::caf_result_type head_res,
   input  caf_pkg::caf_op_type     head_op,
   input  logic [BUF_W-1:0]        head_buf,
   input  logic [OFF_W-1:0]        head_off,
   input  logic [7:0]              head_data,
   output logic                    pop,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output caf_pkg::caf_result_type rsp_res,
   output logic [7:0]              rsp_read_data
);
   import caf_pkg::*;

   localparam int MEM_DEPTH = NUM_BUFFERS * FRAME_BYTES;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   logic [7:0]      frame_mem_ff [MEM_DEPTH];
   logic [7:0]      mem_rd_ff;
   logic            phase_ff;
   logic            s1_valid_ff;
   caf_result_type  s1_res_ff;
   logic            s1_read_ff;
   logic            out_valid_ff;
   caf_result_type  out_res_ff;
   logic [7:0]      out_rdata_ff;

   logic              s1_adv;
   logic              hdr_first;
   logic              take;
   logic              mem_we;
   logic              mem_re;
   logic [7:0]        mem_wdata;
   logic [OFF_W-1:0]  off_sel;
   logic [ADDR_W-1:0] mem_addr;

   always_comb begin
      s1_adv    = s1_valid_ff && (!out_valid_ff || rsp_ready);
      hdr_first = head_valid && (head_op == OP_HEADER) && !phase_ff;
      take      = head_valid && !hdr_first && (!s1_valid_ff || s1_adv);
      mem_we    = hdr_first || (take && ((head_op == OP_WRITE) || (head_op == OP_HEADER)));
      mem_re    = take && (head_op == OP_READ);
      if (hdr_first) begin
         mem_wdata = HDR_FIRST;
      end else if (head_op == OP_HEADER) begin
         mem_wdata = HDR_SECOND;
      end else begin
         mem_wdata = head_data;
      end
      off_sel  = (take && (head_op == OP_HEADER)) ? head_off + 1'b1 : head_off;
      mem_addr = ADDR_W'(ADDR_W'(head_buf) * ADDR_W'(FRAME_BYTES) + ADDR_W'(off_sel));
   end

   assign pop           = take;
   assign rsp_valid     = out_valid_ff;
   assign rsp_res       = out_res_ff;
   assign rsp_read_data = out_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem_ff[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rd_ff <= frame_mem_ff[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_res_ff  <= head_res;
         s1_read_ff <= (head_op == OP_READ);
      end
      if (s1_adv) begin
         out_res_ff   <= s1_res_ff;
         out_rdata_ff <= s1_read_ff ? mem_rd_ff : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (hdr_first) begin
            phase_ff <= 1'b1;
         end else if (take && (head_op == OP_HEADER)) begin
            phase_ff <= 1'b0;
         end
         if (take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: hdl/camera_frame_assembler_unit.sv
// ----------------------------------------------------------------------------
// Camera frame assembler
// Gathers packet bytes into a ring of frame buffers and reports each frame.
//
// Words enter on the req_ channel and each returns exactly one word on the
// rsp_ channel, in order. A word carries a packet byte, an empty packet or
// a read of a stored byte. csr_wr_en writes the enable bit, which gates
// packet input; reads work whatever it holds.
// A word passes the queue, the first back-end stage and the output register
// on its way to rsp_valid. The back end takes one word per cycle while the
// receiver keeps up, set by the single port of the frame memory; a word that
// completes a frame header writes two bytes and so holds that port for both.
// A four-entry queue parts the classifying front end from the memory back
// end, so req_ready stays high while the receiver stalls until it fills.
// Reset empties the queue and output register, clears enable and the frame
// state, and selects buffer one for writing; the memory is not cleared.
// ----------------------------------------------------------------------------
module camera_frame_assembler_unit #(
   parameter int FRAME_BYTES = 65536,
   parameter int NUM_BUFFERS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_of_packet,
   input  logic [9:0]  req_packet_len,
   input  logic [1:0]  req_read_buffer,
   input  logic [15:0] req_read_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_frame_done,
   output logic [1:0]  rsp_done_buffer,
   output logic [16:0] rsp_done_length,
   output logic        rsp_packet_dropped,
   output logic        rsp_packet_ignored,
   output logic [7:0]  rsp_read_data
);
   import caf_pkg::*;

   localparam int BUF_W   = $clog2(NUM_BUFFERS);
   localparam int OFF_W   = $clog2(FRAME_BYTES);
   localparam int RES_W   = $bits(caf_result_type);
   localparam int OP_W    = $bits(caf_op_type);
   localparam int ENTRY_W = RES_W + OP_W + BUF_W + OFF_W + 8;

   logic               accept;
   caf_result_type     ent_res;
   caf_op_type         ent_op;
   logic [BUF_W-1:0]   ent_buf;
   logic [OFF_W-1:0]   ent_off;
   logic [7:0]         ent_data;
   logic [ENTRY_W-1:0] head_entry;
   logic               q_full;
   logic               q_empty;
   logic               pop;
   caf_result_type     head_res;
   logic [OP_W-1:0]    head_op_bits;
   caf_op_type         head_op;
   logic [BUF_W-1:0]   head_buf;
   logic [OFF_W-1:0]   head_off;
   logic [7:0]         head_data;
   caf_result_type     rsp_res;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   caf_front #(
      .FRAME_BYTES (FRAME_BYTES),
      .NUM_BUFFERS (NUM_BUFFERS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .accept          (accept),
      .action          (req_action),
      .data_byte       (req_data_byte),
      .first_of_packet (req_first_of_packet),
      .packet_len      (req_packet_len),
      .read_buffer     (req_read_buffer),
      .read_address    (req_read_address),
      .ent_res         (ent_res),
      .ent_op          (ent_op),
      .ent_buf         (ent_buf),
      .ent_off         (ent_off),
      .ent_data        (ent_data)
   );

   caf_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data ({ent_res, ent_op, ent_buf, ent_off, ent_data}),
      .pop       (pop),
      .head_data (head_entry),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign {head_res, head_op_bits, head_buf, head_off, head_data} = head_entry;
   assign head_op = caf_op_type'(head_op_bits);

   caf_back #(
      .FRAME_BYTES (FRAME_BYTES),
      .NUM_BUFFERS (NUM_BUFFERS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (!q_empty),
      .head_res      (head_res),
      .head_op       (head_op),
      .head_buf      (head_buf),
      .head_off      (head_off),
      .head_data     (head_data),
      .pop           (pop),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_res       (rsp_res),
      .rsp_read_data (rsp_read_data)
   );

   assign rsp_frame_done     = rsp_res.frame_done;
   assign rsp_done_buffer    = rsp_res.done_buffer;
   assign rsp_done_length    = rsp_res.done_length;
   assign rsp_packet_dropped = rsp_res.packet_dropped;
   assign rsp_packet_ignored = rsp_res.packet_ignored;

   a_pop_needs_entry : assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("Back end took a word from an empty queue.");

   a_read_word_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_data != 8'd0) |->
         !rsp_frame_done && !rsp_packet_dropped && !rsp_packet_ignored)
      else $error("Read result carries packet status.");

   a_drop_not_done : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_dropped |-> !rsp_frame_done)
      else $error("Dropped packet reported as a completed frame.");

endmodule
